// ===== rtl/core/fmv_pkg.sv =====
// shared types and constants for the forest majority vote unit
package fmv_pkg;

  localparam int FEAT_W = 4;
  localparam int NUM_W  = 32;
  localparam int LINK_W = 6;
  localparam int TSEL_W = 3;
  localparam int NSEL_W = 6;
  localparam int CNT_W  = 4;

  typedef enum logic [1:0] {
    ACT_NODE     = 2'd0,
    ACT_FEAT     = 2'd1,
    ACT_CLASSIFY = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_NODE,
    S_FEAT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [FEAT_W-1:0]       feat;
    logic signed [NUM_W-1:0] thr;
    logic                    lleaf;
    logic [LINK_W-1:0]       llink;
    logic                    rleaf;
    logic [LINK_W-1:0]       rlink;
  } node_t;

endpackage

// ===== rtl/core/fmv_channels.sv =====
// valid/ready channel interfaces for input and result words
interface fmv_item_if;
  import fmv_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [1:0]              action;
  logic [TSEL_W-1:0]       tree_sel;
  logic [NSEL_W-1:0]       node_sel;
  logic [FEAT_W-1:0]       feature_sel;
  logic signed [NUM_W-1:0] number;
  logic                    left_is_leaf;
  logic [LINK_W-1:0]       left_link;
  logic                    right_is_leaf;
  logic [LINK_W-1:0]       right_link;

  modport source (
    output valid, action, tree_sel, node_sel, feature_sel, number,
           left_is_leaf, left_link, right_is_leaf, right_link,
    input  ready
  );
  modport sink (
    input  valid, action, tree_sel, node_sel, feature_sel, number,
           left_is_leaf, left_link, right_is_leaf, right_link,
    output ready
  );
endinterface

interface fmv_result_if;
  import fmv_pkg::*;
  logic             valid;
  logic             ready;
  logic             predicted_class;
  logic [CNT_W-1:0] ones_votes;
  logic [CNT_W-1:0] zero_votes;
  logic             depth_error;

  modport source (
    output valid, predicted_class, ones_votes, zero_votes, depth_error,
    input  ready
  );
  modport sink (
    input  valid, predicted_class, ones_votes, zero_votes, depth_error,
    output ready
  );
endinterface

// ===== rtl/core/forest_majority_vote_inference_unit.sv =====
// Binary random-forest classifier: node table and feature row in on-chip ram, majority vote out.
// A classify word walks trees 0..min(tree_count, TREES)-1 from their roots; every visited node
// takes two steps, one to read the node ram and one to read the feature ram and compare. New
// words are taken only while the walker is idle; a finished result sits in the output register
// until taken, and the next word may be accepted meanwhile. Feature numbers at or above FEATURES
// compare as zero; a walk that runs past DEPTH_LIMIT nodes or follows a child link at or above
// NODES casts no vote and sets depth_error. A tie or a tree_count of zero gives class 0.
module forest_majority_vote_inference_unit
  import fmv_pkg::*;
#(
  parameter int TREES       = 8,
  parameter int NODES       = 64,
  parameter int FEATURES    = 16,
  parameter int DEPTH_LIMIT = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  fmv_item_if.sink         item,
  fmv_result_if.source     result
);

  localparam int TW        = (TREES > 1) ? $clog2(TREES) : 1;
  localparam int NW        = $clog2(NODES);
  localparam int AW        = TW + NW;
  localparam int FW        = $clog2(FEATURES);
  localparam int DW        = (DEPTH_LIMIT > 1) ? $clog2(DEPTH_LIMIT) : 1;
  localparam int TREES_CAP = (TREES > 15) ? 15 : TREES;

  state_t state, state_next;

  logic [CNT_W-1:0] tree_count;
  logic [CNT_W-1:0] act;
  logic [CNT_W-1:0] tree_idx;
  logic [DW-1:0]    step;
  logic [CNT_W-1:0] ones;
  logic [CNT_W-1:0] zeroes;
  logic             err;
  node_t            node_q;
  logic             feat_ok;
  logic             out_valid;
  logic             out_class;
  logic [CNT_W-1:0] out_ones;
  logic [CNT_W-1:0] out_zeroes;
  logic             out_err;

  // ram ports
  logic             node_we;
  logic [AW-1:0]    node_waddr;
  node_t            node_wdata;
  logic [AW-1:0]    node_raddr;
  node_t            node_rdata;
  logic             feat_we;
  logic [FW-1:0]    feat_waddr;
  logic [FW-1:0]    feat_raddr;
  logic [NUM_W-1:0] feat_rdata;

  // walk decode
  logic signed [NUM_W-1:0] feat_val;
  logic                    go_left;
  logic                    leaf;
  logic [LINK_W-1:0]       link;
  logic                    tree_done;
  logic                    walk_fail;
  logic                    last_tree;
  logic                    accept;
  logic                    load_out;

  assign accept   = item.valid && item.ready;
  assign act      = (int'(tree_count) > TREES) ? CNT_W'(TREES_CAP) : tree_count;
  assign load_out = (state == S_DONE) && (!out_valid || result.ready);

  fmv_ram #(.WIDTH($bits(node_t)), .DEPTH(1 << AW)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  fmv_ram #(.WIDTH(NUM_W), .DEPTH(FEATURES)) u_feat_ram (
    .clk   (clk),
    .we    (feat_we),
    .waddr (feat_waddr),
    .wdata (item.number),
    .raddr (feat_raddr),
    .rdata (feat_rdata)
  );

  always_comb begin
    feat_val  = feat_ok ? $signed(feat_rdata) : '0;
    go_left   = feat_val < node_q.thr;
    leaf      = go_left ? node_q.lleaf : node_q.rleaf;
    link      = go_left ? node_q.llink : node_q.rlink;
    walk_fail = !leaf && ((int'(link) >= NODES) || (step == DW'(DEPTH_LIMIT - 1)));
    tree_done = leaf || walk_fail;
    last_tree = (tree_idx + CNT_W'(1)) == act;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && item.action == ACT_CLASSIFY) begin
          state_next = (act == '0) ? S_DONE : S_NODE;
        end
      end
      S_NODE: state_next = S_FEAT;
      S_FEAT: begin
        if (tree_done && last_tree) begin
          state_next = S_DONE;
        end else begin
          state_next = S_NODE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ram control and handshake outputs
  always_comb begin
    item.ready = 1'b0;
    node_we    = 1'b0;
    feat_we    = 1'b0;
    node_raddr = '0;
    feat_raddr = FW'(node_rdata.feat);
    node_waddr = {TW'(item.tree_sel), NW'(item.node_sel)};
    feat_waddr = FW'(item.feature_sel);
    node_wdata = '{feat: item.feature_sel, thr: item.number,
                   lleaf: item.left_is_leaf, llink: item.left_link,
                   rleaf: item.right_is_leaf, rlink: item.right_link};
    case (state)
      S_IDLE: begin
        item.ready = 1'b1;
        if (accept) begin
          case (action_t'(item.action))
            ACT_NODE: node_we = (int'(item.tree_sel) < TREES) && (int'(item.node_sel) < NODES);
            ACT_FEAT: feat_we = int'(item.feature_sel) < FEATURES;
            default: ;
          endcase
        end
      end
      S_FEAT: begin
        if (!tree_done) begin
          node_raddr = {TW'(tree_idx), NW'(link)};
        end else begin
          node_raddr = {TW'(tree_idx + CNT_W'(1)), NW'(0)};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      tree_count <= CNT_W'(1);
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        tree_count <= cfg_wdata;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        tree_idx <= '0;
        step     <= '0;
        ones     <= '0;
        zeroes   <= '0;
        err      <= 1'b0;
      end
      S_NODE: begin
        node_q  <= node_rdata;
        feat_ok <= int'(node_rdata.feat) < FEATURES;
      end
      S_FEAT: begin
        if (tree_done) begin
          tree_idx <= tree_idx + CNT_W'(1);
          step     <= '0;
          if (walk_fail) begin
            err <= 1'b1;
          end else if (link[0]) begin
            ones <= ones + CNT_W'(1);
          end else begin
            zeroes <= zeroes + CNT_W'(1);
          end
        end else begin
          step <= step + DW'(1);
        end
      end
      default: ;
    endcase
    if (load_out) begin
      out_class  <= ones > zeroes;
      out_ones   <= ones;
      out_zeroes <= zeroes;
      out_err    <= err;
    end
  end

  assign result.valid           = out_valid;
  assign result.predicted_class = out_class;
  assign result.ones_votes      = out_ones;
  assign result.zero_votes      = out_zeroes;
  assign result.depth_error     = out_err;

  // votes cast never exceed the trees in use
  a_vote_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> ((5'(ones) + 5'(zeroes)) <= 5'(act)))
    else $error("vote count exceeds active trees");

  // walker only visits trees in use
  a_tree_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_NODE || state == S_FEAT) |-> (tree_idx < act))
    else $error("walker beyond active trees");

  // depth counter stays under the limit while comparing
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_FEAT) |-> (int'(step) < DEPTH_LIMIT))
    else $error("walk depth counter overflow");

  // classify with trees in use starts with a root read
  a_start_walk: assert property (@(posedge clk) disable iff (rst)
    (accept && item.action == ACT_CLASSIFY && act != '0) |=> (state == S_NODE))
    else $error("classify did not start a walk");

  // a result is only loaded from the done state
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("result loaded outside done state");

endmodule

// ===== rtl/core/fmv_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
module fmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
